// ===== sv/wadx_pkg.sv =====
// Package for the Wilder ADX indicator: widths, limits and codes.
// Used by the interfaces, the top level and the checker.
package wadx_pkg;
   localparam int PRICE_BITS_DEF = 32;
   localparam int MAX_PERIOD_DEF = 255;
   localparam int PERIOD_BITS    = 8;
   localparam int PCT_BITS       = 23;
   localparam int SMOOTH_BITS    = 40;
   localparam int DXSUM_BITS     = 32;
   localparam int COUNT_BITS     = 10;
   localparam logic [PCT_BITS-1:0] PCT_ONE = 23'd6553600;
   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 8'd14;
   localparam int DIV_BITS       = 64;
   localparam int DIV_CNT_BITS   = 7;
endpackage

// ===== sv/wadx_if.sv =====
// Handshake interfaces for bar and result transactions.
// Depends on wadx_pkg.
interface wadx_req_if #(parameter int PRICE_BITS = wadx_pkg::PRICE_BITS_DEF);
   logic                  valid;
   logic                  ready;
   logic [PRICE_BITS-1:0] high_price;
   logic [PRICE_BITS-1:0] low_price;
   logic [PRICE_BITS-1:0] close_price;
   logic                  restart;
   modport source (output valid, high_price, low_price, close_price, restart, input ready);
   modport sink   (input valid, high_price, low_price, close_price, restart, output ready);
endinterface

interface wadx_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [wadx_pkg::PCT_BITS-1:0]  adx_value;
   logic [wadx_pkg::PCT_BITS-1:0]  plus_di;
   logic [wadx_pkg::PCT_BITS-1:0]  minus_di;
   logic                           adx_valid;
   modport source (output valid, adx_value, plus_di, minus_di, adx_valid, input ready);
   modport sink   (input valid, adx_value, plus_di, minus_di, adx_valid, output ready);
endinterface

// ===== sv/wilder_adx_indicator.sv =====
// Wilder ADX indicator over price bars, with one shared restoring divider.
// Depends on wadx_pkg and the interfaces in wadx_if.sv.
//
// One bar transaction is taken at a time, and req.ready is high only while the
// sequencer is idle. Each bar runs through a sequencer that reuses one 64-bit
// restoring divider, which works out one quotient bit per cycle. From the
// accepting edge to the edge that loads the result register:
//  - a first or restart bar passes only through the setup state;
//  - a priming bar passes through the setup state and three smoothing
//    divisions;
//  - a primed bar passes through the setup state and eight divisions:
//    three for smoothing, two DIs, DX, the DX smoothing term and ADX.
// The input is ready again once the sequencer is back in idle. The result
// sits in its own output register until rsp.ready, so the next bar may be
// taken meanwhile. If that bar finishes while the earlier result is still
// unread, the sequencer holds in its final state until the register frees.
module wilder_adx_indicator #(
   parameter int PRICE_BITS = wadx_pkg::PRICE_BITS_DEF,
   parameter int MAX_PERIOD = wadx_pkg::MAX_PERIOD_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [wadx_pkg::PERIOD_BITS-1:0] csr_wr_data,
   wadx_req_if.sink                         req,
   wadx_rsp_if.source                       rsp
);
   localparam int SB = wadx_pkg::SMOOTH_BITS;
   localparam int DB = wadx_pkg::DIV_BITS;
   localparam int CB = wadx_pkg::COUNT_BITS;
   localparam int PB = wadx_pkg::PCT_BITS;
   localparam int NB = wadx_pkg::DIV_CNT_BITS;
   localparam int DXB = wadx_pkg::DXSUM_BITS;
   localparam int XB = PRICE_BITS + 1;
   localparam logic [CB-1:0] COUNT_MAX = {CB{1'b1}};
   localparam logic [SB-1:0] SMAX = {SB{1'b1}};
   localparam logic [DXB-1:0] DXMAX = {DXB{1'b1}};

   typedef enum logic [10:0] {
      S_IDLE = 11'b00000000001, S_PREP = 11'b00000000010, S_SR  = 11'b00000000100,
      S_SP   = 11'b00000001000, S_SM   = 11'b00000010000, S_PDI = 11'b00000100000,
      S_MDI  = 11'b00001000000, S_DX   = 11'b00010000000, S_ADX = 11'b00100000000,
      S_DIV  = 11'b01000000000, S_DXS  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [wadx_pkg::PERIOD_BITS-1:0] period_ff;
   logic [PRICE_BITS-1:0] ph_ff, pl_ff, pc_ff, h_ff, l_ff, c_ff;
   logic [SB-1:0] sr_ff, sp_ff, sm_ff, tr_ff, pdm_ff, mdm_ff;
   logic [DXB-1:0] dxs_ff;
   logic [CB-1:0] cnt_ff, p_ff;
   logic [PB-1:0] pdi_ff, mdi_ff;
   logic [PB-1:0] dx_hold_ff;
   logic restart_ff;
   logic out_v_ff, out_v_in;
   logic [PB-1:0] o_adx_ff, o_pdi_ff, o_mdi_ff;
   logic o_val_ff;
   // divider
   logic [DB-1:0] num_ff, den_ff, quo_ff, rem_ff;
   logic [NB-1:0] dcnt_ff;
   logic [DB:0] trial;

   logic [CB-1:0] p_eff;
   logic [CB-1:0] d_cur, k_cur;
   logic [XB-1:0] up, down, t1, t2, trr;
   logic [DXB-1:0] dxs_base, dxs_nx;
   logic [DXB:0] dxs_sum;
   logic res_st, stall_out;

   function automatic logic [SB-1:0] sadd(input logic [SB:0] a, input logic [SB:0] b);
      logic [SB+1:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {2'b0, SMAX}) ? SMAX : s[SB-1:0];
   endfunction

   always_comb begin
      p_eff = {{(CB-wadx_pkg::PERIOD_BITS){1'b0}}, period_ff};
      if (p_eff == '0) p_eff = CB'(1);
      if (p_eff > CB'(MAX_PERIOD)) p_eff = CB'(MAX_PERIOD);
      d_cur = cnt_ff - CB'(1);
      k_cur = d_cur - p_ff + CB'(1);
      up   = {1'b0, h_ff} - {1'b0, ph_ff};
      down = {1'b0, pl_ff} - {1'b0, l_ff};
      t1 = (h_ff >= pc_ff) ? {1'b0, h_ff - pc_ff} : {1'b0, pc_ff - h_ff};
      t2 = (l_ff >= pc_ff) ? {1'b0, l_ff - pc_ff} : {1'b0, pc_ff - l_ff};
      trr = (h_ff > l_ff) ? {1'b0, h_ff - l_ff} : '0;
      if (t1 > trr) trr = t1;
      if (t2 > trr) trr = t2;
      trial = {rem_ff, num_ff[DB-1]} - {1'b0, den_ff};
      // DX sum update; quo holds dxs/p here
      dxs_base = (k_cur <= p_ff) ? dxs_ff : dxs_ff - quo_ff[DXB-1:0];
      dxs_sum = {1'b0, dxs_base} + {{(DXB+1-PB){1'b0}}, dx_hold_ff};
      dxs_nx = dxs_sum[DXB] ? DXMAX : dxs_sum[DXB-1:0];
   end

   // states that load the result register wait while it still holds an unread result
   always_comb begin
      res_st = (state_ff == S_PREP && (restart_ff || cnt_ff == '0)) ||
               (state_ff == S_SM && d_cur < p_ff) || (state_ff == S_ADX);
      stall_out = res_st && out_v_ff && !rsp.ready;
      out_v_in = out_v_ff;
      if (rsp.valid && rsp.ready) out_v_in = 1'b0;
      if (res_st && !stall_out) out_v_in = 1'b1;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = out_v_ff;
   assign rsp.adx_value = o_adx_ff;
   assign rsp.plus_di = o_pdi_ff;
   assign rsp.minus_di = o_mdi_ff;
   assign rsp.adx_valid = o_val_ff;

   logic [DB-1:0] pdi_w;
   logic [SB-1:0] q_sat;
   logic [PB-1:0] q_pct;
   assign q_sat = (quo_ff > DB'(SMAX)) ? SMAX : quo_ff[SB-1:0];
   assign q_pct = (quo_ff > DB'(wadx_pkg::PCT_ONE)) ? wadx_pkg::PCT_ONE : quo_ff[PB-1:0];
   assign pdi_w = DB'(pdi_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ret_ff <= S_IDLE; out_v_ff <= 1'b0;
         period_ff <= wadx_pkg::PERIOD_RESET;
         ph_ff <= '0; pl_ff <= '0; pc_ff <= '0;
         sr_ff <= '0; sp_ff <= '0; sm_ff <= '0; dxs_ff <= '0; cnt_ff <= '0;
      end else begin
         if (csr_wr_en) period_ff <= csr_wr_data;
         out_v_ff <= out_v_in;
         state_ff <= state_in; ret_ff <= ret_in;
         if (!stall_out) begin
            unique case (state_ff)
               S_IDLE: if (req.valid && req.ready) begin
                  h_ff <= req.high_price; l_ff <= req.low_price; c_ff <= req.close_price;
                  restart_ff <= req.restart;
               end
               S_PREP: begin
                  p_ff <= p_eff;
                  pdi_ff <= '0; mdi_ff <= '0;
                  if (restart_ff || cnt_ff == '0) begin
                     sr_ff <= '0; sp_ff <= '0; sm_ff <= '0; dxs_ff <= '0;
                     cnt_ff <= CB'(1);
                     ph_ff <= h_ff; pl_ff <= l_ff; pc_ff <= c_ff;
                     o_adx_ff <= '0; o_pdi_ff <= '0; o_mdi_ff <= '0; o_val_ff <= 1'b0;
                  end else begin
                     tr_ff <= SB'(trr);
                     pdm_ff <= (!up[XB-1] && up != '0 && $signed(up) > $signed(down))
                               ? SB'(up) : '0;
                     mdm_ff <= (!down[XB-1] && down != '0 && $signed(down) > $signed(up))
                               ? SB'(down) : '0;
                     if (cnt_ff != COUNT_MAX) cnt_ff <= cnt_ff + CB'(1);
                     ph_ff <= h_ff; pl_ff <= l_ff; pc_ff <= c_ff;
                     num_ff <= DB'(sr_ff); den_ff <= DB'(p_eff);
                     rem_ff <= '0; dcnt_ff <= '0;
                  end
               end
               S_DIV: begin
                  if (!trial[DB]) rem_ff <= trial[DB-1:0];
                  else rem_ff <= {rem_ff[DB-2:0], num_ff[DB-1]};
                  quo_ff <= {quo_ff[DB-2:0], !trial[DB]};
                  num_ff <= {num_ff[DB-2:0], 1'b0};
                  dcnt_ff <= dcnt_ff + NB'(1);
               end
               S_SR: begin
                  sr_ff <= (d_cur <= p_ff) ? sadd({1'b0, sr_ff}, {1'b0, tr_ff})
                                          : sadd({1'b0, sr_ff - q_sat}, {1'b0, tr_ff});
                  num_ff <= DB'(sp_ff); den_ff <= DB'(p_ff); rem_ff <= '0; dcnt_ff <= '0;
               end
               S_SP: begin
                  sp_ff <= (d_cur <= p_ff) ? sadd({1'b0, sp_ff}, {1'b0, pdm_ff})
                                          : sadd({1'b0, sp_ff - q_sat}, {1'b0, pdm_ff});
                  num_ff <= DB'(sm_ff); den_ff <= DB'(p_ff); rem_ff <= '0; dcnt_ff <= '0;
               end
               S_SM: begin
                  sm_ff <= (d_cur <= p_ff) ? sadd({1'b0, sm_ff}, {1'b0, mdm_ff})
                                          : sadd({1'b0, sm_ff - q_sat}, {1'b0, mdm_ff});
                  if (d_cur < p_ff) begin
                     o_adx_ff <= '0; o_pdi_ff <= '0; o_mdi_ff <= '0; o_val_ff <= 1'b0;
                  end
                  // DI numerator times 100<<16 fits 64 bits: 40 + 23
                  num_ff <= DB'(sp_ff) * DB'(wadx_pkg::PCT_ONE);
                  den_ff <= DB'(sr_ff); rem_ff <= '0; dcnt_ff <= '0;
               end
               S_PDI: begin
                  pdi_ff <= (den_ff == '0) ? '0 : q_pct;
                  num_ff <= DB'(sm_ff) * DB'(wadx_pkg::PCT_ONE);
                  rem_ff <= '0; dcnt_ff <= '0;
               end
               S_MDI: begin
                  mdi_ff <= (den_ff == '0) ? '0 : q_pct;
                  num_ff <= DB'((pdi_ff >= ((den_ff == '0) ? '0 : q_pct))
                            ? pdi_w - DB'((den_ff == '0) ? '0 : q_pct)
                            : DB'((den_ff == '0) ? '0 : q_pct) - pdi_w)
                            * DB'(wadx_pkg::PCT_ONE);
                  den_ff <= pdi_w + DB'((den_ff == '0) ? '0 : q_pct);
                  rem_ff <= '0; dcnt_ff <= '0;
               end
               S_DX: begin
                  // hold DX while the divider works out dxs/p
                  dx_hold_ff <= (den_ff == '0) ? '0 : q_pct;
                  num_ff <= DB'(dxs_ff); den_ff <= DB'(p_ff);
                  rem_ff <= '0; dcnt_ff <= '0;
               end
               S_DXS: begin
                  dxs_ff <= dxs_nx;
                  num_ff <= DB'(dxs_nx);
                  rem_ff <= '0; dcnt_ff <= '0;
               end
               S_ADX: begin
                  o_pdi_ff <= pdi_ff; o_mdi_ff <= mdi_ff;
                  o_val_ff <= k_cur >= p_ff;
                  o_adx_ff <= (k_cur >= p_ff) ? q_pct : '0;
               end
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      if (!stall_out) begin
         unique case (state_ff)
            S_IDLE: if (req.valid && req.ready) state_in = S_PREP;
            S_PREP: if (restart_ff || cnt_ff == '0) state_in = S_IDLE;
                    else begin state_in = S_DIV; ret_in = S_SR; end
            S_DIV:  if (dcnt_ff == NB'(DB - 1)) state_in = ret_ff;
            S_SR:   begin state_in = S_DIV; ret_in = S_SP; end
            S_SP:   begin state_in = S_DIV; ret_in = S_SM; end
            S_SM:   if (d_cur < p_ff) state_in = S_IDLE;
                    else begin state_in = S_DIV; ret_in = S_PDI; end
            S_PDI:  begin state_in = S_DIV; ret_in = S_MDI; end
            S_MDI:  begin state_in = S_DIV; ret_in = S_DX; end
            S_DX:   begin state_in = S_DIV; ret_in = S_DXS; end
            S_DXS:  begin state_in = S_DIV; ret_in = S_ADX; end
            S_ADX:  state_in = S_IDLE;
            default: state_in = S_IDLE;
         endcase
      end
   end
endmodule

// ===== sv/wadx_checker.sv =====
// Port-level checker for the Wilder ADX indicator, bound to the top level.
// Depends on wadx_pkg.
module wadx_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [wadx_pkg::PCT_BITS-1:0] adx_value,
   input logic [wadx_pkg::PCT_BITS-1:0] plus_di,
   input logic adx_valid
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(adx_value) && $stable(plus_di)
      && $stable(adx_valid)) else $error("result changed while waiting");
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready after transaction");
   a_adx_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> adx_value <= wadx_pkg::PCT_ONE && plus_di <= wadx_pkg::PCT_ONE)
      else $error("value above 100 percent");
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !adx_valid |-> adx_value == '0) else $error("adx without valid");
endmodule

bind wilder_adx_indicator wadx_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .adx_value(rsp.adx_value),
   .plus_di(rsp.plus_di), .adx_valid(rsp.adx_valid)
);
